/* sv/splp_pkg.sv */
// ============================================================================
// splp_pkg
// Shared types and constants for the sparse array linear probe table.
// ============================================================================
package splp_pkg;

    // Table geometry
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CAP_W  = SLOT_W + 1;

    // Field widths
    localparam int DATA_W = 32;
    localparam int CFG_W  = 11;

    // Home slot remainder unit: bits retired per step and step count
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = DATA_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // One table slot as stored in the RAM
    typedef struct packed {
        logic              used;
        logic              deleted;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] data;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic div_step;
        logic home;
        logic advance;
        logic commit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic probe_stop;
        logic is_write;
        logic out_free;
    } status_t;

endpackage

/* sv/splp_ram.sv */
// ============================================================================
// splp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module splp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/splp_ctrl.sv */
// ============================================================================
// splp_ctrl
// Sequencer for the probe table: clearing pass, item intake, home slot
// remainder, probe walk and commit of the write or the read beat.
// ============================================================================
module splp_ctrl
    import splp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_HOME  = 5'b01000,
        S_PROBE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                cmd.home   = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (!status.probe_stop)
                begin
                    cmd.advance = 1'b1;
                end
                else if (status.is_write || status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
                // else: read result waits for the output register
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Checks
    a_no_commit_and_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && cmd.advance))
        else $error("commit and advance in the same cycle");

    a_no_intake_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !in_ready)
        else $error("input taken during clearing pass");

    a_intake_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DIV))
        else $error("accepted beat did not start the remainder unit");

endmodule

/* sv/splp_dp.sv */
// ============================================================================
// splp_dp
// Datapath for the probe table: capacity register, input capture, home slot
// remainder unit, slot RAM, probe position and output register.
// ============================================================================
module splp_dp
    import splp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              mode,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] write_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_value,
    input  cmd_t              cmd,
    output status_t           status
);

    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic                 mode_reg;
    logic [DATA_W-1:0]    key_reg;
    logic [DATA_W-1:0]    val_reg;
    logic [DATA_W-1:0]    mag_reg, mag_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic [SLOT_W-1:0]    n_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    read_value_reg;

    logic [CAP_W-1:0]     home_full;
    logic [SLOT_W-1:0]    home_pos;
    logic [CAP_W-1:0]     pos_inc;
    logic [SLOT_W-1:0]    pos_adv;
    logic                 last_probe;
    logic                 key_match;
    logic                 live_hit;
    logic                 found;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    slot_t                ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    slot_t                ram_rdata;

    // Capacity register, held as the effective modulus
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_next = CAP_W'(1);
        end
        else if (32'(cfg_data) > 32'(SLOTS))
        begin
            cap_next = CAP_W'(SLOTS);
        end
        else
        begin
            cap_next = CAP_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(SLOTS);
        end
        else if (cfg_valid)
        begin
            cap_reg <= cap_next;
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            val_reg  <= write_value;
        end
    end

    // Remainder unit: |key| mod capacity, DIV_BITS bits per step, MSB first
    always_comb
    begin
        logic [CAP_W-1:0] trial;
        mag_next = mag_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_next, mag_next[DATA_W-1]};
            mag_next = {mag_next[DATA_W-2:0], 1'b0};
            if (trial >= cap_reg)
            begin
                trial = trial - cap_reg;
            end
            rem_next = trial[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= key[DATA_W-1] ? (~key + DATA_W'(1)) : key;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    // Non-negative home slot
    assign home_full = (key_reg[DATA_W-1] && (rem_reg != '0))
                     ? (cap_reg - CAP_W'(rem_reg)) : CAP_W'(rem_reg);
    assign home_pos  = home_full[SLOT_W-1:0];

    // Probe position with wrap at the capacity
    assign pos_inc    = CAP_W'(pos_reg) + CAP_W'(1);
    assign pos_adv    = (pos_inc == cap_reg) ? '0 : pos_inc[SLOT_W-1:0];
    assign last_probe = (n_reg == SLOT_W'(cap_reg - CAP_W'(1)));

    always_ff @(posedge clk)
    begin
        if (cmd.home)
        begin
            pos_reg <= home_pos;
            n_reg   <= '0;
        end
        else if (cmd.advance)
        begin
            pos_reg <= pos_adv;
            n_reg   <= n_reg + SLOT_W'(1);
        end
    end

    // Slot evaluation on the registered read data
    assign key_match = (ram_rdata.key == key_reg);
    assign live_hit  = ram_rdata.used && key_match && !ram_rdata.deleted;
    assign found     = !ram_rdata.used || key_match;

    always_comb
    begin
        status.clear_done = (clr_cnt_reg == SLOT_W'(SLOTS - 1));
        status.div_done   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        status.is_write   = mode_reg;
        status.out_free   = !out_valid_reg || out_ready;
        if (mode_reg)
        begin
            status.probe_stop = found || last_probe;
        end
        else
        begin
            status.probe_stop = !ram_rdata.used || live_hit || last_probe;
        end
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
        end
    end

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = '0;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (cmd.commit && mode_reg && found)
        begin
            if (val_reg != '0)
            begin
                ram_we            = 1'b1;
                ram_wdata.used    = 1'b1;
                ram_wdata.deleted = 1'b0;
                ram_wdata.key     = key_reg;
                ram_wdata.data    = val_reg;
            end
            else if (ram_rdata.used)
            begin
                ram_we            = 1'b1;
                ram_wdata         = ram_rdata;
                ram_wdata.deleted = 1'b1;
            end
        end

        if (cmd.home)
        begin
            ram_raddr = home_pos;
        end
        else if (cmd.advance)
        begin
            ram_raddr = pos_adv;
        end
        else
        begin
            ram_raddr = pos_reg;
        end
    end

    splp_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit && !mode_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !mode_reg)
        begin
            read_value_reg <= live_hit ? ram_rdata.data : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

    // Checks
    a_beat_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit && !mode_reg))
        else $error("output beat not caused by a read");

    a_no_write_outside_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cmd.clear || (cmd.commit && mode_reg)))
        else $error("slot RAM written outside clear or write commit");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(read_value_reg)))
        else $error("stalled result beat dropped or changed");

endmodule

/* sv/sparse_array_linear_probe_table.sv */
// Read path: intake, remainder steps in S_DIV, home slot, then one probe per slot visited;
//   result beat registered at the commit after the last probe, which waits while the output is full.
// Intake: a new item is taken only in S_IDLE, once the previous one has committed; paced by the
//   4-bit-per-cycle remainder unit and the single slot RAM read port (one slot per cycle).
// Reset: async active-low; then a clearing pass over all SLOTS (1024) slots with
//   in_ready low. Capacity resets to 1024; cfg writes are taken at any time.
// ============================================================================
// sparse_array_linear_probe_table
// Sparse integer array in an open-addressing hash table with linear probing.
// ============================================================================
module sparse_array_linear_probe_table
    import splp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] write_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_value
);

    cmd_t    cmd;
    status_t status;

    // Capacity register is always writable
    assign cfg_ready = 1'b1;

    splp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    splp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .key         (key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
